>>> src/tfec_pkg.sv
// ---------------------------------------------------------------------------
// Three-floor elevator controller package
// Shared types and fixed constants: call codes, operation codes, register
// indexes, byte codes and reset values.
// ---------------------------------------------------------------------------
package tfec_pkg;

  // Number of floors served by the car.
  localparam int unsigned FLOORS = 3;

  // Kind of request held for a floor.
  typedef enum logic [1:0] {
    CALL_NONE = 2'd0,
    CALL_USER = 2'd1,
    CALL_IDLE = 2'd2
  } call_t;

  // Operation carried by an input word.
  typedef enum logic {
    OP_CALL = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_DOOR_CLEAR_LOW  = 1'b0,
    REG_DOOR_CLEAR_HIGH = 1'b1
  } reg_idx_t;

  // ASCII codes of the floor call bytes '0' and '2'.
  localparam logic [7:0] BYTE_FLOOR_ZERO = 8'd48;
  localparam logic [7:0] BYTE_FLOOR_TWO  = 8'd50;

  // Highest floor number and saturation limit of a visit count.
  localparam logic [1:0] TOP_FLOOR = 2'd2;
  localparam logic [3:0] TALLY_MAX = 4'd15;

  // Reset values of the door clear window, in cm.
  localparam logic [8:0] DOOR_CLEAR_LOW_RST  = 9'd40;
  localparam logic [8:0] DOOR_CLEAR_HIGH_RST = 9'd45;

endpackage

>>> src/three_floor_elevator_controller.sv
// ---------------------------------------------------------------------------
// Three-floor elevator controller
// A word accepted at the input is held in the input register, and its
// result word is registered in the result register once that register is
// free or being read; out_valid then stays high until out_ready takes it.
// Throughput: one word per cycle while out_ready is high; each word passes
// once through the input register, the update logic and the result register.
// Reset (rst_n low, synchronous): car at floor 0, door closed, no calls,
// empty history and counts, clear window 40..45 cm; history entries hold
// no reset value and are only read after they have been written.
// ---------------------------------------------------------------------------
module three_floor_elevator_controller #(
  parameter int HISTORY_LEN = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_call_byte,
  input  logic       in_flame_alarm,
  input  logic       in_gas_alarm,
  input  logic [8:0] in_door_distance_cm,
  // Result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_car_floor,
  output logic       out_moving_up,
  output logic       out_moving_down,
  output logic       out_door_is_open,
  output logic [1:0] out_alarm_kind,
  output logic [1:0] out_home_floor,
  output logic [3:0] out_visits_floor_zero,
  output logic [3:0] out_visits_floor_one,
  output logic [3:0] out_visits_floor_two,
  // Configuration port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata
);

  localparam int SLOT_W = $clog2(HISTORY_LEN);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_LEN - 1);
  localparam logic [5:0] HIST_LEN_W = 6'(HISTORY_LEN);

  // Configuration registers
  logic [8:0] door_clear_low_r;
  logic [8:0] door_clear_high_r;

  // Input register
  logic       in_valid_r;
  logic       op_r;
  logic [7:0] call_byte_r;
  logic       flame_r;
  logic       gas_r;
  logic [8:0] dist_r;

  // Controller state
  logic [1:0]          floor_now_r, floor_now_nxt;
  tfec_pkg::call_t     pend_r [tfec_pkg::FLOORS];
  tfec_pkg::call_t     pend_nxt [tfec_pkg::FLOORS];
  logic [2:0]          door_wanted_r, door_wanted_nxt;
  logic                door_state_r, door_state_nxt;
  logic [1:0]          hist_r [HISTORY_LEN];
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic [3:0]          tally_r [tfec_pkg::FLOORS];
  logic [3:0]          tally_nxt [tfec_pkg::FLOORS];
  logic [1:0]          fav_r, fav_nxt;

  // Result register
  logic       out_valid_r;
  logic [1:0] out_floor_r;
  logic       out_up_r;
  logic       out_down_r;
  logic       out_door_r;
  logic [1:0] out_alarm_r;
  logic [1:0] out_home_r;
  logic [3:0] out_t0_r, out_t1_r, out_t2_r;

  // Handshake between the two register stages
  logic fire;
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  // Floor with the highest count; the lower floor wins a tie.
  function automatic logic [1:0] busiest(input logic [3:0] t0, input logic [3:0] t1,
                                         input logic [3:0] t2);
    logic [1:0] best;
    logic [3:0] best_cnt;
    best     = 2'd2;
    best_cnt = t2;
    if (t1 >= best_cnt) begin
      best     = 2'd1;
      best_cnt = t1;
    end
    if (t0 >= best_cnt) begin
      best = 2'd0;
    end
    return best;
  endfunction

  // Decoded call byte
  logic [7:0] call_off;
  logic       call_hit;
  logic [1:0] call_floor;
  assign call_off   = call_byte_r - tfec_pkg::BYTE_FLOOR_ZERO;
  assign call_hit   = (call_byte_r >= tfec_pkg::BYTE_FLOOR_ZERO) &&
                      (call_byte_r <= tfec_pkg::BYTE_FLOOR_TWO);
  assign call_floor = call_off[1:0];

  logic [1:0] alarm;
  assign alarm = {gas_r, flame_r};

  logic       up, down;
  logic       arr_en;
  logic [1:0] arr_floor;
  logic       log_en;
  logic       door_clear;
  logic       idle_en;

  assign door_clear = (dist_r >= door_clear_low_r) && (dist_r <= door_clear_high_r);

  // Main update: call registration, door closing, one-floor move, arrival
  // and idle target. An arrival always opens the door, so the idle check
  // never sees a count changed in the same word.
  always_comb begin
    floor_now_nxt   = floor_now_r;
    pend_nxt        = pend_r;
    door_wanted_nxt = door_wanted_r;
    door_state_nxt  = door_state_r;
    fav_nxt         = fav_r;
    up              = 1'b0;
    down            = 1'b0;
    arr_en          = 1'b0;
    arr_floor       = 2'd0;
    log_en          = 1'b0;
    idle_en         = 1'b0;

    if (op_r == tfec_pkg::OP_CALL) begin
      if (call_hit) begin
        pend_nxt[call_floor] = tfec_pkg::CALL_USER;
      end
    end else if (alarm == 2'd0) begin
      if (door_state_r) begin
        if (door_clear) begin
          door_state_nxt             = 1'b0;
          door_wanted_nxt[floor_now_r] = 1'b0;
          idle_en                    = 1'b1;
        end
      end else begin
        // Move toward the lowest floor with a pending call.
        if (pend_r[0] != tfec_pkg::CALL_NONE) begin
          if (floor_now_r != 2'd0) begin
            floor_now_nxt = floor_now_r - 2'd1;
            down          = 1'b1;
          end else begin
            arr_en    = 1'b1;
            arr_floor = 2'd0;
          end
        end else if (pend_r[1] != tfec_pkg::CALL_NONE) begin
          if (floor_now_r == 2'd0) begin
            floor_now_nxt = 2'd1;
            up            = 1'b1;
          end else if (floor_now_r == tfec_pkg::TOP_FLOOR) begin
            floor_now_nxt = 2'd1;
            down          = 1'b1;
          end else begin
            arr_en    = 1'b1;
            arr_floor = 2'd1;
          end
        end else if (pend_r[2] != tfec_pkg::CALL_NONE) begin
          if (floor_now_r != tfec_pkg::TOP_FLOOR) begin
            floor_now_nxt = floor_now_r + 2'd1;
            up            = 1'b1;
          end else begin
            arr_en    = 1'b1;
            arr_floor = tfec_pkg::TOP_FLOOR;
          end
        end

        // Arrival: log a user call, drop the call, ask for the door.
        if (arr_en) begin
          log_en                     = (pend_r[arr_floor] == tfec_pkg::CALL_USER);
          pend_nxt[arr_floor]        = tfec_pkg::CALL_NONE;
          door_wanted_nxt[arr_floor] = 1'b1;
        end

        if (door_wanted_nxt[floor_now_nxt]) begin
          door_state_nxt = 1'b1;
        end else begin
          idle_en = 1'b1;
        end
      end
    end

    // Idle target: with no call left, head for the busiest recent floor.
    if (idle_en && pend_nxt[0] == tfec_pkg::CALL_NONE &&
        pend_nxt[1] == tfec_pkg::CALL_NONE && pend_nxt[2] == tfec_pkg::CALL_NONE) begin
      fav_nxt = busiest(tally_r[0], tally_r[1], tally_r[2]);
      if (floor_now_nxt != fav_nxt) begin
        pend_nxt[fav_nxt] = tfec_pkg::CALL_IDLE;
      end
    end
  end

  // Arrival history: retire the oldest entry once the window is full,
  // then count the new arrival, saturating.
  logic [1:0] old_floor;
  assign old_floor = hist_r[slot_r];

  always_comb begin
    tally_nxt   = tally_r;
    slot_nxt    = slot_r;
    wrapped_nxt = wrapped_r;
    if (log_en) begin
      if (wrapped_r && old_floor != 2'd3 && tally_nxt[old_floor] != 4'd0) begin
        tally_nxt[old_floor] = tally_nxt[old_floor] - 4'd1;
      end
      if (tally_nxt[arr_floor] != tfec_pkg::TALLY_MAX) begin
        tally_nxt[arr_floor] = tally_nxt[arr_floor] + 4'd1;
      end
      if (slot_r == LAST_SLOT) begin
        slot_nxt    = '0;
        wrapped_nxt = 1'b1;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
  end

  // History store, written at the current slot on a logged arrival.
  always_ff @(posedge clk) begin
    if (fire && log_en) begin
      hist_r[slot_r] <= arr_floor;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_clear_low_r  <= tfec_pkg::DOOR_CLEAR_LOW_RST;
      door_clear_high_r <= tfec_pkg::DOOR_CLEAR_HIGH_RST;
    end else if (cfg_we) begin
      if (cfg_index == tfec_pkg::REG_DOOR_CLEAR_LOW) begin
        door_clear_low_r <= cfg_wdata;
      end else begin
        door_clear_high_r <= cfg_wdata;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r        <= in_op;
      call_byte_r <= in_call_byte;
      flame_r     <= in_flame_alarm;
      gas_r       <= in_gas_alarm;
      dist_r      <= in_door_distance_cm;
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_now_r   <= 2'd0;
      pend_r        <= '{default: tfec_pkg::CALL_NONE};
      door_wanted_r <= 3'b000;
      door_state_r  <= 1'b0;
      slot_r        <= '0;
      wrapped_r     <= 1'b0;
      tally_r       <= '{default: 4'd0};
      fav_r         <= 2'd0;
    end else if (fire) begin
      floor_now_r   <= floor_now_nxt;
      pend_r        <= pend_nxt;
      door_wanted_r <= door_wanted_nxt;
      door_state_r  <= door_state_nxt;
      slot_r        <= slot_nxt;
      wrapped_r     <= wrapped_nxt;
      tally_r       <= tally_nxt;
      fav_r         <= fav_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_floor_r <= floor_now_nxt;
      out_up_r    <= up;
      out_down_r  <= down;
      out_door_r  <= door_state_nxt;
      out_alarm_r <= (op_r == tfec_pkg::OP_TICK) ? alarm : 2'd0;
      out_home_r  <= fav_nxt;
      out_t0_r    <= tally_nxt[0];
      out_t1_r    <= tally_nxt[1];
      out_t2_r    <= tally_nxt[2];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_car_floor         = out_floor_r;
  assign out_moving_up         = out_up_r;
  assign out_moving_down       = out_down_r;
  assign out_door_is_open      = out_door_r;
  assign out_alarm_kind        = out_alarm_r;
  assign out_home_floor        = out_home_r;
  assign out_visits_floor_zero = out_t0_r;
  assign out_visits_floor_one  = out_t1_r;
  assign out_visits_floor_two  = out_t2_r;

  // An alarm tick leaves the car and the door exactly as they were.
  a_alarm_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op_r == tfec_pkg::OP_TICK && alarm != 2'd0
    |=> $stable(floor_now_r) && $stable(door_state_r) && $stable(slot_r))
    else $error("alarm tick changed controller state");

  // The car never moves while the door is open.
  a_no_move_open: assert property (@(posedge clk) disable iff (!rst_n)
    fire && door_state_r |=> !out_moving_up && !out_moving_down)
    else $error("car moved with the door open");

  // The car only ever stands at one of the three floors.
  a_floor_range: assert property (@(posedge clk) disable iff (!rst_n)
    floor_now_r != 2'd3)
    else $error("car floor out of range");

  // The counts never add up to more than the history window holds.
  a_tally_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ({2'b00, tally_r[0]} + {2'b00, tally_r[1]} + {2'b00, tally_r[2]}) <= HIST_LEN_W)
    else $error("visit counts exceed the history window");

  // Reported upward motion advances the car by one floor.
  a_move_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && up |=> floor_now_r == $past(floor_now_r) + 2'd1)
    else $error("upward move did not advance one floor");

endmodule
